FILE: hdl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and codes of the keyed record table: commands, internal
// operations, result status codes and the queued command record.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

	localparam int CNT_W = 7;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_DEL = 2'd1;
	localparam logic [1:0] CMD_UPD = 2'd2;
	localparam logic [1:0] CMD_GET = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_DUP       = 3'd2;
	localparam logic [2:0] ST_GET_MISS  = 3'd3;
	localparam logic [2:0] ST_DEL_MISS  = 3'd4;
	localparam logic [2:0] ST_UPD_TAKEN = 3'd5;
	localparam logic [2:0] ST_UPD_MISS  = 3'd6;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_DEL     = 3'd1,
		OP_UPD_CHK = 3'd2,
		OP_UPD     = 3'd3,
		OP_GET     = 3'd4
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] key;
		logic signed [31:0] new_key;
		logic [63:0]        payload;
	} cmd_t;

endpackage

`default_nettype wire

FILE: hdl/krt_front.sv
// ----------------------------------------------------------------------------
// krt_front
// Input stage: takes one command per transfer, decodes it into an internal
// operation and holds it in a register until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] new_key,
	input  wire logic [63:0]        payload,
	output logic                    q_valid,
	input  wire logic               q_ready,
	output krt_pkg::cmd_t           q_data
);

	logic          v_s1;
	krt_pkg::cmd_t cmd_s1;
	krt_pkg::cmd_t dec;

	always_comb begin
		dec.key = key;
		dec.new_key = new_key;
		dec.payload = payload;
		unique case (cmd)
			krt_pkg::CMD_ADD: dec.op = krt_pkg::OP_ADD;
			krt_pkg::CMD_DEL: dec.op = krt_pkg::OP_DEL;
			krt_pkg::CMD_UPD: dec.op = (new_key == key) ? krt_pkg::OP_UPD : krt_pkg::OP_UPD_CHK;
			krt_pkg::CMD_GET: dec.op = krt_pkg::OP_GET;
			default: dec.op = krt_pkg::OP_GET;
		endcase
	end

	assign in_ready = !v_s1 || q_ready;
	assign q_valid = v_s1;
	assign q_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (q_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= dec;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/krt_fifo.sv
// ----------------------------------------------------------------------------
// krt_fifo
// Two-entry command queue between the decoder and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire krt_pkg::cmd_t wr_data,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output krt_pkg::cmd_t      rd_data
);

	krt_pkg::cmd_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          push;
	logic          pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_data = ent_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/krt_engine.sv
// ----------------------------------------------------------------------------
// krt_engine
// Table engine: key and payload memories, a sequencer that scans the live
// slots one per cycle and closes the gap after a delete, the live count and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_engine #(
	parameter int DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_valid,
	output logic                           cmd_ready,
	input  wire krt_pkg::cmd_t             cmd_data,
	input  wire logic [krt_pkg::CNT_W-1:0] cap,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [2:0]                     status,
	output logic signed [31:0]             found_key,
	output logic [63:0]                    found_payload,
	output logic [krt_pkg::CNT_W-1:0]      record_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = krt_pkg::CNT_W;
	localparam logic [31:0] DEPTH_W = 32'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_MOVE = 3'b100
	} state_t;

	logic signed [31:0] key_mem [DEPTH];
	logic [63:0]        pay_mem [DEPTH];

	state_t             state_q, state_d;
	krt_pkg::op_t       op_q, op_d;
	krt_pkg::cmd_t      cur_q;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic               pend_s1, pend_d;
	logic [CW-1:0]      pidx_s1, pidx_d;
	logic signed [31:0] rkey_q;
	logic [63:0]        rpay_q;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic signed [31:0] fkey_q;
	logic [63:0]        fpay_q;
	logic [CW-1:0]      count_q;

	logic               slot_free;
	logic               start;
	logic               hit;
	logic               more;
	logic               at_limit;
	logic signed [31:0] target;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_key;
	logic [63:0]        wr_pay;
	logic               load;
	logic [2:0]         ld_status;
	logic signed [31:0] ld_fkey;
	logic [63:0]        ld_fpay;

	assign slot_free = !out_valid_q || out_ready;
	assign cmd_ready = (state_q == S_IDLE) && slot_free;
	assign start = cmd_ready && cmd_valid;
	assign target = (op_q == krt_pkg::OP_UPD_CHK) ? cur_q.new_key : cur_q.key;
	assign hit = pend_s1 && (rkey_q == target);
	assign more = (idx_q < cnt_q);
	assign at_limit = (cnt_q >= cap) || ({{(32 - CW){1'b0}}, cnt_q} >= DEPTH_W);

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		idx_d = idx_q;
		pend_d = 1'b0;
		pidx_d = pidx_s1;
		cnt_d = cnt_q;
		rd_en = 1'b0;
		rd_addr = AW'(idx_q);
		wr_en = 1'b0;
		wr_addr = AW'(cnt_q);
		wr_key = cur_q.key;
		wr_pay = cur_q.payload;
		load = 1'b0;
		ld_status = krt_pkg::ST_OK;
		ld_fkey = '0;
		ld_fpay = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d = cmd_data.op;
					idx_d = '0;
					if (cmd_data.op == krt_pkg::OP_ADD && at_limit) begin
						load = 1'b1;
						ld_status = krt_pkg::ST_FULL;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_IDLE;
					unique case (op_q)
						krt_pkg::OP_ADD: begin
							load = 1'b1;
							ld_status = krt_pkg::ST_DUP;
						end
						krt_pkg::OP_GET: begin
							load = 1'b1;
							ld_fkey = rkey_q;
							ld_fpay = rpay_q;
						end
						krt_pkg::OP_UPD_CHK: begin
							load = 1'b1;
							ld_status = krt_pkg::ST_UPD_TAKEN;
						end
						krt_pkg::OP_UPD: begin
							wr_en = 1'b1;
							wr_addr = AW'(pidx_s1);
							wr_key = cur_q.new_key;
							load = 1'b1;
						end
						krt_pkg::OP_DEL: begin
							idx_d = pidx_s1 + 1'b1;
							state_d = S_MOVE;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end else if (more) begin
					rd_en = 1'b1;
					pend_d = 1'b1;
					pidx_d = idx_q;
					idx_d = idx_q + 1'b1;
				end else if (!pend_s1) begin
					state_d = S_IDLE;
					load = 1'b1;
					unique case (op_q)
						krt_pkg::OP_ADD: begin
							wr_en = 1'b1;
							cnt_d = cnt_q + 1'b1;
						end
						krt_pkg::OP_DEL: ld_status = krt_pkg::ST_DEL_MISS;
						krt_pkg::OP_GET: ld_status = krt_pkg::ST_GET_MISS;
						krt_pkg::OP_UPD: ld_status = krt_pkg::ST_UPD_MISS;
						krt_pkg::OP_UPD_CHK: begin
							load = 1'b0;
							op_d = krt_pkg::OP_UPD;
							idx_d = '0;
							state_d = S_SCAN;
						end
						default: ld_status = krt_pkg::ST_OK;
					endcase
				end
			end
			S_MOVE: begin
				if (pend_s1) begin
					wr_en = 1'b1;
					wr_addr = AW'(pidx_s1 - 1'b1);
					wr_key = rkey_q;
					wr_pay = rpay_q;
				end
				if (more) begin
					rd_en = 1'b1;
					pend_d = 1'b1;
					pidx_d = idx_q;
					idx_d = idx_q + 1'b1;
				end else if (!pend_s1) begin
					cnt_d = cnt_q - 1'b1;
					load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			pend_s1 <= pend_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		idx_q <= idx_d;
		pidx_s1 <= pidx_d;
		if (start) begin
			cur_q <= cmd_data;
		end
		if (load) begin
			status_q <= ld_status;
			fkey_q <= ld_fkey;
			fpay_q <= ld_fpay;
			count_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_pay;
		end
		if (rd_en) begin
			rkey_q <= key_mem[rd_addr];
			rpay_q <= pay_mem[rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found_key = fkey_q;
	assign found_payload = fpay_q;
	assign record_count = count_q;

endmodule

`default_nettype wire

FILE: hdl/keyed_record_table.sv
// Commands pass the decode register and the queue; the engine then scans the
// live slots, twice for an update to a new key, and a delete also moves the
// later records down; an add to a full table answers without a scan.
// Throughput: one command at a time in the engine, set by the one-slot-per-
// cycle scan of the key memory; up to three commands wait ahead.
// Reset clears the count, the queue and all handshakes; capacity resets to 64.
// ----------------------------------------------------------------------------
// keyed_record_table
// Bounded table of records with unique signed keys and 64-bit payloads,
// supporting add, delete with compaction, update and get.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table #(
	parameter int DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [6:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] new_key,
	input  wire logic [63:0]        payload,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic signed [31:0]      found_key,
	output logic [63:0]             found_payload,
	output logic [6:0]              record_count
);

	logic [6:0]    capacity_q;
	logic          fq_valid;
	logic          fq_ready;
	krt_pkg::cmd_t fq_data;
	logic          eq_valid;
	logic          eq_ready;
	krt_pkg::cmd_t eq_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	krt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.key      (key),
		.new_key  (new_key),
		.payload  (payload),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	krt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (eq_valid),
		.rd_ready (eq_ready),
		.rd_data  (eq_data)
	);

	krt_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (eq_valid),
		.cmd_ready     (eq_ready),
		.cmd_data      (eq_data),
		.cap           (capacity_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.found_key     (found_key),
		.found_payload (found_payload),
		.record_count  (record_count)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({25'd0, record_count} <= 32'(DEPTH)))
		else $error("record count exceeds table depth");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != krt_pkg::ST_OK |-> found_key == 0 && found_payload == 0)
		else $error("found fields not zero on an error result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= krt_pkg::ST_UPD_MISS)
		else $error("status code out of range");
`endif

endmodule

`default_nettype wire

FILE: verif/keyed_record_table_tb.sv
// ----------------------------------------------------------------------------
// keyed_record_table_tb
// Self-checking bench for the keyed record table. A scoreboard keeps its own
// copy of the table and predicts the status, found record and live count of
// every command at the moment it is accepted. Each returned result is checked
// in order against those predictions. A short directed run is followed by
// randomized phases under several capacity settings, with random idling on
// both channels, a long output stall and a full drain in the middle.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table_tb;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_POOL_SIZE = 40;
	localparam int N_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 100;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] found_key;
		logic [63:0]        found_payload;
		logic [6:0]         record_count;
	} table_result_t;

	class table_scoreboard #(int DEPTH = 64);
		logic signed [31:0] keys[DEPTH];
		logic [63:0]        payloads[DEPTH];
		int unsigned        live;
		logic [6:0]         capacity;
		table_result_t      expected[$];
		int unsigned        mismatches;

		function new();
			live = 0;
			capacity = 7'd64;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [6:0] value);
			capacity = value;
		endfunction

		function int find_slot(logic signed [31:0] k);
			for (int i = 0; i < live; i++) begin
				if (keys[i] == k)
					return i;
			end
			return -1;
		endfunction

		function int unsigned pending();
			return expected.size();
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			$display("mismatch in %s: got %h, expected %h", what, got, want);
		endtask

		function void note_command(logic [1:0] c, logic signed [31:0] k,
				logic signed [31:0] nk, logic [63:0] pl);
			table_result_t r;
			int unsigned limit;
			int slot;
			r = '0;
			r.status = krt_pkg::ST_OK;
			limit = (capacity < DEPTH) ? capacity : DEPTH;
			case (c)
				krt_pkg::CMD_ADD: begin
					if (live >= limit) begin
						r.status = krt_pkg::ST_FULL;
					end else if (find_slot(k) >= 0) begin
						r.status = krt_pkg::ST_DUP;
					end else begin
						keys[live] = k;
						payloads[live] = pl;
						live++;
					end
				end
				krt_pkg::CMD_DEL: begin
					slot = find_slot(k);
					if (slot < 0) begin
						r.status = krt_pkg::ST_DEL_MISS;
					end else begin
						for (int j = slot; j + 1 < live; j++) begin
							keys[j] = keys[j + 1];
							payloads[j] = payloads[j + 1];
						end
						live--;
					end
				end
				krt_pkg::CMD_UPD: begin
					if (nk != k && find_slot(nk) >= 0) begin
						r.status = krt_pkg::ST_UPD_TAKEN;
					end else begin
						slot = find_slot(k);
						if (slot < 0) begin
							r.status = krt_pkg::ST_UPD_MISS;
						end else begin
							keys[slot] = nk;
							payloads[slot] = pl;
						end
					end
				end
				default: begin
					slot = find_slot(k);
					if (slot < 0) begin
						r.status = krt_pkg::ST_GET_MISS;
					end else begin
						r.found_key = keys[slot];
						r.found_payload = payloads[slot];
					end
				end
			endcase
			r.record_count = live[6:0];
			expected.push_back(r);
		endfunction

		task check_result(logic [2:0] st, logic signed [31:0] fk,
				logic [63:0] fp, logic [6:0] cnt);
			table_result_t want;
			if (expected.size() == 0) begin
				report_mismatch("result with no command waiting", {61'd0, st}, 64'd0);
				return;
			end
			want = expected.pop_front();
			if (st !== want.status)
				report_mismatch("status", {61'd0, st}, {61'd0, want.status});
			if (fk !== want.found_key)
				report_mismatch("found_key", {32'd0, fk}, {32'd0, want.found_key});
			if (fp !== want.found_payload)
				report_mismatch("found_payload", fp, want.found_payload);
			if (cnt !== want.record_count)
				report_mismatch("record_count", {57'd0, cnt}, {57'd0, want.record_count});
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [6:0]         cfg_data = 7'd0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         cmd = krt_pkg::CMD_ADD;
	logic signed [31:0] key = '0;
	logic signed [31:0] new_key = '0;
	logic [63:0]        payload = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] found_key;
	logic [63:0]        found_payload;
	logic [6:0]         record_count;

	logic               hold_results = 1'b0;
	int unsigned        recv_idle_pct = 0;
	int unsigned        send_idle_pct = 0;
	logic signed [31:0] key_pool[KEY_POOL_SIZE];
	table_scoreboard #(TABLE_DEPTH) board;

	keyed_record_table #(.DEPTH(TABLE_DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.key          (key),
		.new_key      (new_key),
		.payload      (payload),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.found_key    (found_key),
		.found_payload(found_payload),
		.record_count (record_count)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(status, found_key, found_payload, record_count);
	end

	initial begin
		#12_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic send_cmd(input logic [1:0] c, input logic signed [31:0] k,
			input logic signed [31:0] nk, input logic [63:0] pl);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 30)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		key <= k;
		new_key <= nk;
		payload <= pl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_command(c, k, nk, pl);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (board.pending() != 0);
		@(posedge clk);
	endtask

	task automatic write_capacity(input logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_capacity(value);
		cfg_valid <= 1'b0;
	endtask

	task automatic hold_receiver(input int cycles);
		hold_results <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_results <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45 && board.live > 0)
			return board.keys[$urandom_range(board.live - 1)];
		if (r < 80)
			return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic random_cmd(input int unsigned add_pct);
		logic [1:0]         c;
		logic signed [31:0] k;
		logic signed [31:0] nk;
		int unsigned        r;
		if ($urandom_range(99) < add_pct) begin
			c = krt_pkg::CMD_ADD;
		end else begin
			case ($urandom_range(2))
				0: c = krt_pkg::CMD_DEL;
				1: c = krt_pkg::CMD_UPD;
				default: c = krt_pkg::CMD_GET;
			endcase
		end
		k = pick_key();
		r = $urandom_range(9);
		if (r < 3)
			nk = k;
		else
			nk = pick_key();
		send_cmd(c, k, nk, {$urandom, $urandom});
	endtask

	task automatic directed_cmds();
		send_cmd(krt_pkg::CMD_GET, KEY_MIN, 32'sd0, 64'd0);
		send_cmd(krt_pkg::CMD_DEL, KEY_MAX, 32'sd0, 64'd0);
		send_cmd(krt_pkg::CMD_UPD, 32'sd5, 32'sd5, 64'h1234_5678_9ABC_DEF0);
		send_cmd(krt_pkg::CMD_ADD, KEY_MIN, 32'sd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(krt_pkg::CMD_ADD, KEY_MAX, 32'sd0, 64'd0);
		send_cmd(krt_pkg::CMD_ADD, 32'sd0, 32'sd0, 64'h4A6F_686E_2053_6D69);
		send_cmd(krt_pkg::CMD_ADD, 32'sd0, 32'sd0, 64'h5555_5555_5555_5555);
		send_cmd(krt_pkg::CMD_GET, KEY_MAX, 32'sd0, 64'd0);
		send_cmd(krt_pkg::CMD_UPD, 32'sd0, KEY_MIN, 64'hAAAA_AAAA_AAAA_AAAA);
		send_cmd(krt_pkg::CMD_UPD, 32'sd123, KEY_MAX, 64'h0F0F_0F0F_0F0F_0F0F);
		send_cmd(krt_pkg::CMD_UPD, 32'sd0, 32'sd0, 64'h8000_0000_0000_0001);
		send_cmd(krt_pkg::CMD_UPD, 32'sd0, -32'sd1, 64'h7FFF_FFFF_FFFF_FFFE);
		send_cmd(krt_pkg::CMD_DEL, KEY_MIN, 32'sd0, 64'd0);
		send_cmd(krt_pkg::CMD_GET, -32'sd1, 32'sd0, 64'd0);
		send_cmd(krt_pkg::CMD_GET, 32'sd0, 32'sd0, 64'd0);
		send_cmd(krt_pkg::CMD_DEL, -32'sd1, 32'sd0, 64'd0);
		wait_drained();
		write_capacity(7'd1);
		send_cmd(krt_pkg::CMD_ADD, 32'sd5, 32'sd0, 64'd5);
		send_cmd(krt_pkg::CMD_GET, KEY_MAX, 32'sd0, 64'd0);
		wait_drained();
		write_capacity(7'd0);
		send_cmd(krt_pkg::CMD_ADD, 32'sd7, 32'sd0, 64'd7);
		send_cmd(krt_pkg::CMD_DEL, KEY_MAX, 32'sd0, 64'd0);
		send_cmd(krt_pkg::CMD_ADD, 32'sd7, 32'sd0, 64'd7);
		wait_drained();
	endtask

	initial begin
		int unsigned phase_cap[N_PHASES] = '{64, 127, 40, 3, 64, 1, 127, 0, 64, 20, 127, 64};
		int unsigned phase_add[N_PHASES] = '{70, 55, 40, 30, 65, 40, 70, 30, 50, 45, 60, 35};
		board = new();
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_cmds();

		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 26;
				recv_idle_pct <= 60;
			end else if (p < 8) begin
				send_idle_pct = 60;
				recv_idle_pct <= 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			write_capacity(phase_cap[p][6:0]);
			if (p == 4) begin
				fork
					hold_receiver(600);
				join_none
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 2 && n == ITEMS_PER_PHASE / 2)
					wait_drained();
				random_cmd(phase_add[p]);
			end
			wait_drained();
		end

		repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
		if (board.pending() == 0 && board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
